// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ratio estimator.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPO2_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPO2_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPO2_ASSERT_IMPL(lbl, ante, cons)
`define SPO2_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/spo2_pkg.sv
// Shared constants for the pulse oximetry ratio estimator.
// Depends on nothing; used by spo2_sqrt and the top level of the block.
package spo2_pkg;
   localparam int SAMPLE_PORT_W = 18;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int RADICAND_W    = 64;
   localparam int ROOT_W        = 36;
   localparam int ROOT_STEPS    = 36;
   localparam int RATIO_STEPS   = 16;

   localparam logic [2:0] STATUS_WARMUP = 3'd0;
   localparam logic [2:0] STATUS_NO_DC  = 3'd1;
   localparam logic [2:0] STATUS_WEAK   = 3'd2;
   localparam logic [2:0] STATUS_RANGE  = 3'd3;
   localparam logic [2:0] STATUS_UPDATE = 3'd4;

   localparam logic [2:0] CSR_VALID_MIN = 3'd0;
   localparam logic [2:0] CSR_VALID_MAX = 3'd1;
   localparam logic [2:0] CSR_WEIGHT    = 3'd2;
   localparam logic [2:0] CSR_MIN_IR    = 3'd3;
   localparam logic [2:0] CSR_MIN_RED   = 3'd4;
   localparam logic [2:0] CSR_OFFSET    = 3'd5;
   localparam logic [2:0] CSR_SLOPE     = 3'd6;

   localparam logic [15:0] DECAY_MUL   = 16'd63570;
   localparam logic [15:0] ONE_Q88     = 16'd256;
   localparam logic [8:0]  WEIGHT_FULL = 9'd256;
endpackage

// File: rtl/spo2_win_mem.sv
// Sample window memory: one write and one registered read port per cycle.
// Depends on nothing.
module spo2_win_mem #(
   parameter int DEPTH = 25,
   parameter int DW    = 36,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/spo2_sqrt.sv
// Iterative square root giving floor(16*sqrt(v)), one result bit per cycle.
// Depends on spo2_pkg.
module spo2_sqrt import spo2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RADICAND_W-1:0] radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);
   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_STEPS + 1);

   logic [RADICAND_W-1:0] val_ff;
   logic [REM_W-1:0]      rem_ff, rem_sh, trial;
   logic [ROOT_W-1:0]     root_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;

   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[RADICAND_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_STEPS - 1);
            val_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            val_ff <= val_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// File: rtl/spo2_div.sv
// Restoring divider by a narrow divisor, one quotient bit per cycle.
// Depends on nothing.
module spo2_div #(
   parameter int DW = 36,
   parameter int NW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]  dvd_ff, quo_ff;
   logic [NW-1:0]  dsr_ff, rem_ff;
   logic [NW:0]    rem_sh;
   logic [CNT_W-1:0] cnt_ff;
   logic           busy_ff, done_ff;

   assign rem_sh = {rem_ff, dvd_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW - 1);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= dvd_ff << 1;
            if (rem_sh >= {1'b0, dsr_ff}) begin
               rem_ff <= NW'(rem_sh - {1'b0, dsr_ff});
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= NW'(rem_sh);
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: rtl/pulse_oximetry_ratio_estimator.sv
// Pulse oximetry ratio-of-ratios estimator, top level.
// Depends on spo2_pkg, spo2_win_mem, spo2_sqrt, spo2_div and assert_macros.svh.
// A warm-up request goes from acceptance straight to its response; a full request reads
// the n filled entries from memory, one read per entry, then runs 36 square root steps,
// 36 divide steps by n and 16 ratio steps in sequence.
// One request is processed at a time. Synchronous reset clears the window pointers,
// the estimate and the registers to their defaults; the window memory is not cleared.
`include "assert_macros.svh"
module pulse_oximetry_ratio_estimator import spo2_pkg::*; #(
   parameter int WINDOW_DEPTH = 25,
   parameter int SAMPLE_WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SAMPLE_PORT_W-1:0] req_red_sample,
   input  logic [SAMPLE_PORT_W-1:0] req_ir_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              rsp_saturation,
   output logic [15:0]              rsp_ratio,
   output logic [2:0]               rsp_status,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);
   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int CW     = $clog2(WINDOW_DEPTH + 1);
   localparam int SW     = SAMPLE_WIDTH;
   localparam int SUM_W  = SW + CW;
   localparam int SQ_W   = 2 * SW;
   localparam int QS_W   = SQ_W + CW;
   localparam int V_W    = QS_W + CW;
   localparam int AC_W   = SW + 4;
   localparam int PROD_W = AC_W + SUM_W;
   localparam int RD_W   = PROD_W + 4;
   localparam int HALF   = WINDOW_DEPTH / 2;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ACC   = 4'd1;
   localparam logic [3:0] ST_DRAIN = 4'd2;
   localparam logic [3:0] ST_VAR   = 4'd3;
   localparam logic [3:0] ST_VAR2  = 4'd4;
   localparam logic [3:0] ST_SQRT  = 4'd5;
   localparam logic [3:0] ST_DIVN  = 4'd6;
   localparam logic [3:0] ST_CHK   = 4'd7;
   localparam logic [3:0] ST_RINIT = 4'd8;
   localparam logic [3:0] ST_RDIV  = 4'd9;
   localparam logic [3:0] ST_CAL   = 4'd10;
   localparam logic [3:0] ST_UPD   = 4'd11;
   localparam logic [3:0] ST_FIN   = 4'd12;

   logic [3:0]  state_ff;
   logic [15:0] vmin_ff, vmax_ff, min_ir_ff, min_red_ff, offset_ff, slope_ff;
   logic [8:0]  weight_ff;
   logic [AW-1:0] wpos_ff, rd_idx_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [15:0] est_ff, ratio_ff;
   logic [2:0]  status_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_sat_ff, rsp_ratio_ff;
   logic [2:0]  rsp_status_ff;

   logic          accept;
   logic [SW-1:0] red_m, ir_m;
   logic [2*SW-1:0] mem_rd;
   logic          rd_vld_ff, sq_vld_ff;
   logic [SW-1:0] x_red_ff, x_ir_ff;
   logic [SQ_W-1:0] sq_red_ff, sq_ir_ff;
   logic [SUM_W-1:0] sum_red_ff, sum_ir_ff;
   logic [QS_W-1:0]  qs_red_ff, qs_ir_ff;
   logic [V_W-1:0]   nq_red_ff, nq_ir_ff, ss_red_ff, ss_ir_ff;
   logic           sqrt_start, sqrt_red_done, sqrt_ir_done;
   logic [ROOT_W-1:0] root_red, root_ir, quo_red, quo_ir;
   logic           div_start, div_red_done, div_ir_done;
   logic [AC_W-1:0] ac_red_ff, ac_ir_ff;
   logic [PROD_W-1:0] num_ff, den_ff;
   logic [RD_W-1:0]  rrem_ff, rdiv_ff, rrem_sh;
   logic [3:0]       rstep_ff;
   logic signed [33:0] raw20_ff, raw20_in, lo20, hi20;
   logic [27:0]    raw_rnd;
   logic [15:0]    raw16, decayed, ema;
   logic [31:0]    decay_prod, slope_prod;
   logic [8:0]     w_eff;
   logic [24:0]    ema_acc;
   logic           fin_fire, no_ratio_rsp;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign red_m     = SW'(req_red_sample);
   assign ir_m      = SW'(req_ir_sample);
   assign fill_in   = (fill_ff == CW'(WINDOW_DEPTH)) ? fill_ff : fill_ff + CW'(1);

   spo2_win_mem #(.DEPTH(WINDOW_DEPTH), .DW(2 * SW), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wpos_ff),
      .wr_data ({red_m, ir_m}),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd)
   );

   assign sqrt_start = (state_ff == ST_VAR2);
   assign div_start  = (state_ff == ST_SQRT) && sqrt_red_done;

   spo2_sqrt u_sqrt_red (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .radicand (RADICAND_W'(nq_red_ff - ss_red_ff)),
      .done (sqrt_red_done), .root (root_red)
   );
   spo2_sqrt u_sqrt_ir (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .radicand (RADICAND_W'(nq_ir_ff - ss_ir_ff)),
      .done (sqrt_ir_done), .root (root_ir)
   );
   spo2_div #(.DW(ROOT_W), .NW(CW)) u_div_red (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (root_red), .divisor (fill_ff),
      .done (div_red_done), .quotient (quo_red)
   );
   spo2_div #(.DW(ROOT_W), .NW(CW)) u_div_ir (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (root_ir), .divisor (fill_ff),
      .done (div_ir_done), .quotient (quo_ir)
   );

   assign rrem_sh    = rrem_ff << 1;
   assign decay_prod = est_ff * DECAY_MUL;
   assign decayed    = (est_ff > ONE_Q88) ? decay_prod[31:16] : 16'd0;
   assign slope_prod = 32'(slope_ff) * 32'(ratio_ff);
   assign raw20_in   = $signed({6'b0, offset_ff, 12'b0}) - $signed({2'b0, slope_prod});
   assign lo20       = $signed({6'b0, vmin_ff, 12'b0});
   assign hi20       = $signed({6'b0, vmax_ff, 12'b0});
   assign raw_rnd    = 28'(raw20_ff + 34'sd2048);
   assign raw16      = raw_rnd[27:12];
   assign w_eff      = (weight_ff > WEIGHT_FULL) ? WEIGHT_FULL : weight_ff;
   assign ema_acc    = 25'(w_eff) * 25'(raw16) + 25'(WEIGHT_FULL - w_eff) * 25'(est_ff)
                       + 25'd128;
   assign ema        = ema_acc[23:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff    <= 16'd17920;
         vmax_ff    <= 16'd25600;
         weight_ff  <= 9'd26;
         min_ir_ff  <= 16'd160;
         min_red_ff <= 16'd80;
         offset_ff  <= 16'd28160;
         slope_ff   <= 16'd6400;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VALID_MIN: vmin_ff    <= csr_wr_data;
            CSR_VALID_MAX: vmax_ff    <= csr_wr_data;
            CSR_WEIGHT:    weight_ff  <= csr_wr_data[8:0];
            CSR_MIN_IR:    min_ir_ff  <= csr_wr_data;
            CSR_MIN_RED:   min_red_ff <= csr_wr_data;
            CSR_OFFSET:    offset_ff  <= csr_wr_data;
            CSR_SLOPE:     slope_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Window read pipeline: memory read, square, accumulate.
   always_ff @(posedge clock) begin
      x_red_ff  <= mem_rd[2*SW-1:SW];
      x_ir_ff   <= mem_rd[SW-1:0];
      sq_red_ff <= mem_rd[2*SW-1:SW] * mem_rd[2*SW-1:SW];
      sq_ir_ff  <= mem_rd[SW-1:0] * mem_rd[SW-1:0];
      if (reset) begin
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_ACC);
         sq_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         est_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (sq_vld_ff) begin
            sum_red_ff <= sum_red_ff + SUM_W'(x_red_ff);
            sum_ir_ff  <= sum_ir_ff + SUM_W'(x_ir_ff);
            qs_red_ff  <= qs_red_ff + QS_W'(sq_red_ff);
            qs_ir_ff   <= qs_ir_ff + QS_W'(sq_ir_ff);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wpos_ff    <= (wpos_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_ff + AW'(1);
                  fill_ff    <= fill_in;
                  ratio_ff   <= '0;
                  rd_idx_ff  <= '0;
                  sum_red_ff <= '0;
                  sum_ir_ff  <= '0;
                  qs_red_ff  <= '0;
                  qs_ir_ff   <= '0;
                  if (fill_in < CW'(HALF)) begin
                     status_ff <= STATUS_WARMUP;
                     state_ff  <= ST_FIN;
                  end else begin
                     state_ff <= ST_ACC;
                  end
               end
            end
            ST_ACC: begin
               if ((CW'(rd_idx_ff) + CW'(1)) == fill_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  rd_idx_ff <= rd_idx_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               if (!rd_vld_ff && !sq_vld_ff) begin
                  state_ff <= ST_VAR;
               end
            end
            ST_VAR: begin
               nq_red_ff <= fill_ff * qs_red_ff;
               nq_ir_ff  <= fill_ff * qs_ir_ff;
               ss_red_ff <= sum_red_ff * sum_red_ff;
               ss_ir_ff  <= sum_ir_ff * sum_ir_ff;
               if (sum_red_ff < SUM_W'(fill_ff) || sum_ir_ff < SUM_W'(fill_ff)) begin
                  status_ff <= STATUS_NO_DC;
                  state_ff  <= ST_FIN;
               end else begin
                  state_ff <= ST_VAR2;
               end
            end
            ST_VAR2: begin
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (sqrt_red_done) begin
                  state_ff <= ST_DIVN;
               end
            end
            ST_DIVN: begin
               if (div_red_done) begin
                  ac_red_ff <= AC_W'(quo_red);
                  ac_ir_ff  <= AC_W'(quo_ir);
                  state_ff  <= ST_CHK;
               end
            end
            ST_CHK: begin
               num_ff <= ac_red_ff * sum_ir_ff;
               den_ff <= ac_ir_ff * sum_red_ff;
               if (32'(ac_ir_ff) < 32'(min_ir_ff) || 32'(ac_red_ff) < 32'(min_red_ff)) begin
                  status_ff <= STATUS_WEAK;
                  est_ff    <= decayed;
                  state_ff  <= ST_FIN;
               end else begin
                  state_ff <= ST_RINIT;
               end
            end
            ST_RINIT: begin
               rrem_ff  <= RD_W'(num_ff);
               rdiv_ff  <= RD_W'({den_ff, 3'b0});
               rstep_ff <= 4'(RATIO_STEPS - 1);
               if (den_ff == '0 || RD_W'(num_ff) >= RD_W'({den_ff, 4'b0})) begin
                  ratio_ff <= 16'hFFFF;
                  state_ff <= ST_CAL;
               end else begin
                  state_ff <= ST_RDIV;
               end
            end
            ST_RDIV: begin
               if (rrem_ff >= rdiv_ff) begin
                  rrem_ff  <= (rrem_ff - rdiv_ff) << 1;
                  ratio_ff <= {ratio_ff[14:0], 1'b1};
               end else begin
                  rrem_ff  <= rrem_sh;
                  ratio_ff <= {ratio_ff[14:0], 1'b0};
               end
               rstep_ff <= rstep_ff - 4'd1;
               if (rstep_ff == 4'd0) begin
                  state_ff <= ST_CAL;
               end
            end
            ST_CAL: begin
               raw20_ff <= raw20_in;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (raw20_ff < lo20 || raw20_ff > hi20) begin
                  status_ff <= STATUS_RANGE;
                  est_ff    <= decayed;
               end else begin
                  status_ff <= STATUS_UPDATE;
                  est_ff    <= (est_ff < vmin_ff) ? raw16 : ema;
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sat_ff    <= est_ff;
                  rsp_ratio_ff  <= ratio_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_ratio      = rsp_ratio_ff;
   assign rsp_status     = rsp_status_ff;

   assign fin_fire     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign no_ratio_rsp = rsp_valid_ff && (rsp_status_ff == STATUS_WARMUP ||
                         rsp_status_ff == STATUS_NO_DC || rsp_status_ff == STATUS_WEAK);

   `SPO2_ASSERT_IMPL(a_sqrt_lockstep, sqrt_red_done != sqrt_ir_done, 1'b0)
   `SPO2_ASSERT_IMPL(a_div_lockstep, div_red_done != div_ir_done, 1'b0)
   `SPO2_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= CW'(WINDOW_DEPTH))
   `SPO2_ASSERT_NEXT(a_fin_loads, fin_fire, rsp_valid_ff && state_ff == ST_IDLE)
   `SPO2_ASSERT_IMPL(a_no_ratio, no_ratio_rsp, rsp_ratio_ff == 16'd0)
endmodule
